// File: design/mrfc_pkg.sv
// Shared types and constants for the Modbus RTU frame checker.
// No dependencies; every other design file imports this package.
`default_nettype none

package mrfc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam int unsigned COUNT_W = 3;

   // Byte count thresholds, saturating at the minimum frame length.
   localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 3'd4;
   localparam logic [COUNT_W-1:0] FN_CODE_POS = 3'd1;
   localparam logic [COUNT_W-1:0] CRC_FEED_POS = 3'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_BAD_FN    = 2'd2,
      STATUS_CRC_ERROR = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] computed_crc;
      logic [15:0] trailer_crc;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/mrfc_crc_step.sv
// One-byte update of the reflected CRC-16 (polynomial 0xA001), unrolled.
// Depends on mrfc_pkg.
`default_nettype none

module mrfc_crc_step (
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data,
   output logic      [15:0] crc_next
);
   import mrfc_pkg::*;

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// File: design/mrfc_frame_core.sv
// Frame state (CRC, held bytes, byte count, function code) and the checks
// made on the final byte. Depends on mrfc_pkg and mrfc_crc_step.
`default_nettype none

module mrfc_frame_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   output logic                  result_valid,
   output mrfc_pkg::rsp_type     result
);
   import mrfc_pkg::*;

   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         older_ff, older_in;
   logic [7:0]         newer_ff, newer_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         fn_code_ff, fn_code_in;
   logic [15:0]        crc_fed;

   mrfc_crc_step u_crc_step (
      .crc_cur  (crc_ff),
      .data     (older_ff),
      .crc_next (crc_fed)
   );

   function automatic logic fn_code_standard(input logic [7:0] fc);
      logic ok;
      case (fc)
         8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd15, 8'd16: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   always_comb begin
      logic [15:0]        crc_upd;
      logic [COUNT_W-1:0] count_upd;
      logic [7:0]         fn_upd;

      // The held older byte is two positions behind the incoming one.
      crc_upd   = (count_ff >= CRC_FEED_POS) ? crc_fed : crc_ff;
      fn_upd    = (count_ff == FN_CODE_POS) ? data_byte : fn_code_ff;
      count_upd = (count_ff < MIN_FRAME_LEN) ? count_ff + 1'b1 : count_ff;

      result.computed_crc = crc_upd;
      result.trailer_crc  = {data_byte, newer_ff};
      if (count_upd < MIN_FRAME_LEN) begin
         result.status = STATUS_SHORT;
      end else if (!fn_code_standard(fn_upd)) begin
         result.status = STATUS_BAD_FN;
      end else if (crc_upd != {data_byte, newer_ff}) begin
         result.status = STATUS_CRC_ERROR;
      end else begin
         result.status = STATUS_OK;
      end
      result_valid = accept && last_byte;

      crc_in     = crc_ff;
      older_in   = older_ff;
      newer_in   = newer_ff;
      count_in   = count_ff;
      fn_code_in = fn_code_ff;
      if (accept) begin
         if (last_byte) begin
            crc_in     = CRC_INIT;
            older_in   = '0;
            newer_in   = '0;
            count_in   = '0;
            fn_code_in = '0;
         end else begin
            crc_in     = crc_upd;
            older_in   = newer_ff;
            newer_in   = data_byte;
            count_in   = count_upd;
            fn_code_in = fn_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= CRC_INIT;
         older_ff   <= '0;
         newer_ff   <= '0;
         count_ff   <= '0;
         fn_code_ff <= '0;
      end else begin
         crc_ff     <= crc_in;
         older_ff   <= older_in;
         newer_ff   <= newer_in;
         count_ff   <= count_in;
         fn_code_ff <= fn_code_in;
      end
   end

endmodule

`default_nettype wire

// File: design/mrfc_rsp_reg.sv
// Result register with valid/ready handshake toward the result channel.
// Depends on mrfc_pkg.
`default_nettype none

module mrfc_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire mrfc_pkg::rsp_type load_data,
   output logic                   free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mrfc_pkg::rsp_type      rsp_data
);
   import mrfc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // The register can take a new result when empty or when its result
   // is being transferred in this cycle.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// File: design/modbus_rtu_frame_checker.sv
// Modbus RTU frame checker: one frame byte per transfer, CRC-16 and checks.
// The result is registered, valid in the cycle after the final byte is taken.
// One byte per cycle unless stalled; the byte-wide CRC update sets the path.
// A byte is taken whenever the result register is empty or drains that cycle.
// Synchronous reset empties the result register and restarts the frame.
`default_nettype none

module modbus_rtu_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_computed_crc,
   output logic [15:0]      rsp_trailer_crc
);
   import mrfc_pkg::*;

   logic    accept;
   logic    result_valid;
   logic    out_free;
   rsp_type result;
   rsp_type rsp_data;

   assign req_ready = out_free;
   assign accept    = req_valid && req_ready;

   mrfc_frame_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .last_byte    (req_last_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   mrfc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_data (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_status       = rsp_data.status;
   assign rsp_computed_crc = rsp_data.computed_crc;
   assign rsp_trailer_crc  = rsp_data.trailer_crc;

endmodule

`default_nettype wire

// File: design/mrfc_checker.sv
// Port-level checks for the Modbus RTU frame checker, bound to the top level.
// Depends on mrfc_pkg and modbus_rtu_frame_checker.
`default_nettype none

module mrfc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_data_byte,
   input wire logic        req_last_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_computed_crc,
   input wire logic [15:0] rsp_trailer_crc
);
   import mrfc_pkg::*;

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_computed_crc) && $stable(rsp_trailer_crc))
      else $error("result changed while stalled");

   // The final byte of a frame yields a result in the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid)
      else $error("no result after final byte");

   a_ok_crc_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_computed_crc == rsp_trailer_crc)
      else $error("ok status with mismatching CRC");

   a_err_crc_differs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CRC_ERROR
         |-> rsp_computed_crc != rsp_trailer_crc)
      else $error("CRC error status with matching CRC");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind modbus_rtu_frame_checker mrfc_checker u_mrfc_checker (.*);

`default_nettype wire

// File: verif/tb_modbus_rtu_frame_checker.sv
// Self-checking testbench for modbus_rtu_frame_checker: directed frames, then random
// well-formed, corrupted and short frames with random idling on both sides.
// Depends on mrfc_pkg (status codes, result type, CRC constants) and the DUT.
module tb_modbus_rtu_frame_checker;
   import mrfc_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      rsp_type    result;
   } byte_row_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CRC,
      FRAME_BAD_FN,
      FRAME_SHORT,
      FRAME_NOISE
   } frame_kind_type;

   localparam int RANDOM_BYTES = 800;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int PRESSURE_FRAMES = 12;
   localparam int NUM_ROWS = 26;
   localparam logic [7:0] STANDARD_FN_CODES [8] = '{8'd1, 8'd2, 8'd3, 8'd4,
                                                   8'd5, 8'd6, 8'd15, 8'd16};
   localparam rsp_type NO_RESULT = '{STATUS_OK, 16'h0000, 16'h0000};

   // Rows with typed set carry a result that can be read straight off the frame.
   localparam byte_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{8'hA5, 1'b1, 1'b1, '{STATUS_SHORT, 16'hFFFF, 16'hA500}},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b1, '{STATUS_SHORT, 16'hFFFF, 16'hFF00}},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, 1'b0, NO_RESULT},
      '{8'h7E, 1'b1, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h0A, 1'b0, 1'b0, NO_RESULT},
      '{8'hC5, 1'b0, 1'b0, NO_RESULT},
      '{8'hCD, 1'b1, 1'b1, '{STATUS_OK, 16'hCDC5, 16'hCDC5}},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h0A, 1'b0, 1'b0, NO_RESULT},
      '{8'hC5, 1'b0, 1'b0, NO_RESULT},
      '{8'hCE, 1'b1, 1'b1, '{STATUS_CRC_ERROR, 16'hCDC5, 16'hCEC5}},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b0, NO_RESULT}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_computed_crc;
   logic [15:0] rsp_trailer_crc;

   // Frame tracker state, mirroring the checker's running CRC and byte history.
   logic [15:0] frame_crc;
   logic [7:0]  frame_older_byte;
   logic [7:0]  frame_newer_byte;
   logic [2:0]  frame_byte_count;
   logic [7:0]  frame_fn_code;

   rsp_type expected_results [$];
   int      mismatches;
   int      bytes_sent;
   int      frames_sent;
   int      results_checked;
   int      status_counts [4];
   bit      sender_gaps;
   bit      receiver_gaps;
   bit      hold_request;

   modbus_rtu_frame_checker uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_trailer_crc  (rsp_trailer_crc)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_modbus(input logic [15:0] seed, input logic [7:0] b);
      logic [15:0] c;
      c = seed ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic bit is_standard_fn(input logic [7:0] fn);
      foreach (STANDARD_FN_CODES[i]) begin
         if (STANDARD_FN_CODES[i] == fn) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic clear_frame_state();
      frame_crc = CRC_INIT;
      frame_older_byte = 8'h00;
      frame_newer_byte = 8'h00;
      frame_byte_count = 3'd0;
      frame_fn_code = 8'h00;
   endtask

   // Advances the frame tracker by one byte and queues the result on a final byte.
   task automatic track_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input rsp_type typed_result);
      rsp_type r;
      if (frame_byte_count >= CRC_FEED_POS) frame_crc = crc16_modbus(frame_crc, frame_older_byte);
      if (frame_byte_count == FN_CODE_POS) frame_fn_code = b;
      frame_older_byte = frame_newer_byte;
      frame_newer_byte = b;
      if (frame_byte_count < MIN_FRAME_LEN) frame_byte_count = frame_byte_count + 3'd1;
      if (fin) begin
         r.computed_crc = frame_crc;
         r.trailer_crc = {frame_newer_byte, frame_older_byte};
         if (frame_byte_count < MIN_FRAME_LEN) r.status = STATUS_SHORT;
         else if (!is_standard_fn(frame_fn_code)) r.status = STATUS_BAD_FN;
         else if (frame_crc != r.trailer_crc) r.status = STATUS_CRC_ERROR;
         else r.status = STATUS_OK;
         expected_results.push_back(typed ? typed_result : r);
         frames_sent++;
         clear_frame_state();
      end
   endtask

   // Offers one byte after an optional gap and returns at the edge of its transfer.
   task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                            input rsp_type typed_result);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      track_byte(b, fin, typed, typed_result);
   endtask

   task automatic send_random_frame(input frame_kind_type kind);
      logic [7:0]  frame_bytes [$];
      logic [7:0]  fn;
      logic [15:0] crc;
      int          len;
      case (kind)
         FRAME_SHORT: begin
            len = $urandom_range(1, 3);
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         FRAME_NOISE: begin
            len = $urandom_range(1, 12);
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            if (kind == FRAME_BAD_FN) begin
               do fn = 8'($urandom_range(0, 255)); while (is_standard_fn(fn));
            end else begin
               fn = STANDARD_FN_CODES[$urandom_range(0, 7)];
            end
            frame_bytes.push_back(fn);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
            crc = CRC_INIT;
            foreach (frame_bytes[i]) crc = crc16_modbus(crc, frame_bytes[i]);
            if (kind == FRAME_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
         end
      endcase
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_RESULT);
      end
   endtask

   initial begin : stimulus
      int pick;
      frame_kind_type kind;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      mismatches = 0;
      bytes_sent = 0;
      frames_sent = 0;
      results_checked = 0;
      status_counts = '{0, 0, 0, 0};
      sender_gaps = 1'b1;
      hold_request = 1'b0;
      clear_frame_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].result);
      end

      // Back-to-back frames while the receiver is held off fill the result register.
      hold_request = 1'b1;
      sender_gaps = 1'b0;
      repeat (PRESSURE_FRAMES) send_random_frame(FRAME_GOOD);

      while (bytes_sent < NUM_ROWS + RANDOM_BYTES) begin
         sender_gaps = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 70) kind = FRAME_GOOD;
         else if (pick < 80) kind = FRAME_BAD_CRC;
         else if (pick < 88) kind = FRAME_BAD_FN;
         else if (pick < 95) kind = FRAME_SHORT;
         else kind = FRAME_NOISE;
         send_random_frame(kind);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d frames; checked %0d results.",
               bytes_sent, frames_sent, results_checked);
      $display("Status mix: ok %0d, too short %0d, bad function %0d, CRC mismatch %0d.",
               status_counts[STATUS_OK], status_counts[STATUS_SHORT],
               status_counts[STATUS_BAD_FN], status_counts[STATUS_CRC_ERROR]);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : result_drain
      int stall;
      rsp_ready = 1'b0;
      receiver_gaps = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 15) == 0) receiver_gaps = !receiver_gaps;
         stall = receiver_gaps ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: status %0d computed %h trailer %h",
                     $time, rsp_status, rsp_computed_crc, rsp_trailer_crc);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            status_counts[want.status]++;
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               mismatches++;
            end
            if (rsp_computed_crc !== want.computed_crc) begin
               $display("%0t: computed_crc expected %h actual %h",
                        $time, want.computed_crc, rsp_computed_crc);
               mismatches++;
            end
            if (rsp_trailer_crc !== want.trailer_crc) begin
               $display("%0t: trailer_crc expected %h actual %h",
                        $time, want.trailer_crc, rsp_trailer_crc);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
